[rtl/core/plie_pkg.sv]
// Shared types, codes and helpers for the positional list insert/erase unit.
`default_nettype none
package plie_pkg;

    // Wide enough for a position or a count at the largest supported capacity.
    localparam int POS_W = 11;
    localparam int DATA_W = 32;
    localparam int TREE_RADIX = 16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PAST  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_READ
    } t_cell_op;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] new_value;
        logic [7:0]         position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         entry_count;
        t_status            status;
    } t_out_item;

    // Broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op            op;
        logic [POS_W-1:0]    pos;
        logic [DATA_W-1:0]   value;
    } t_cell_ctl;

    // Register levels of the read-back OR tree for n leaves.
    function automatic int tree_levels(input int n);
        int lv;
        int span;
        lv = 1;
        span = TREE_RADIX;
        while (span < n) begin
            span = span * TREE_RADIX;
            lv = lv + 1;
        end
        return lv;
    endfunction

endpackage
`default_nettype wire

[rtl/core/positional_list_insert_erase_unit.sv]
// Positional list insert/erase/read unit: top level with control and result queue.
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a row of cells
// that all shift in the same cycle. Insert, erase, no-op and empty-list read items
// are queued in the cycle they are accepted; any other read first passes the
// L = ceil(log16(CAPACITY)) levels of the registered OR tree that brings the selected
// cell out (L is 2 at the default capacity of 64), and the next item is taken once
// the read result is queued. Results go into a two-entry queue, so items keep flowing
// while a result waits on a stalled output. Stored entries come up undefined; only
// entries below the count are ever returned.
`default_nettype none
module positional_list_insert_erase_unit
    import plie_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int L  = tree_levels(CAPACITY);
    localparam int LW = (L > 1) ? $clog2(L) : 1;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_busy;
    logic [LW-1:0]     r_wait;
    t_out_item         r_pend;
    t_out_item         r_fifo [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_fcnt;

    t_cell_ctl         w_ctl;
    t_out_item         w_res;
    t_out_item         w_push_item;
    logic              w_accept;
    logic              w_imm_push;
    logic              w_tree_start;
    logic              w_tree_done;
    logic              w_push;
    logic              w_pop;
    logic [POS_W-1:0]  w_pos;
    logic [POS_W-1:0]  w_cnt;
    logic              w_full;
    logic              w_empty;
    logic [DATA_W-1:0] w_entry [CAPACITY];
    logic [DATA_W-1:0] w_rd    [CAPACITY];
    logic [DATA_W-1:0] w_tree_val;

    assign o_in_stall  = r_busy || (r_fcnt == 2'd2);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_tree_done = r_busy && (r_wait == '0);
    assign o_out_valid = (r_fcnt != 2'd0);
    assign o_out_item  = r_fifo[r_rd_ptr];
    assign w_pop       = o_out_valid && !i_out_stall;

    assign w_pos   = POS_W'(i_in_item.position);
    assign w_cnt   = POS_W'(r_count);
    assign w_full  = (w_cnt == POS_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_ctl.op     = CELL_HOLD;
        w_ctl.pos    = w_pos;
        w_ctl.value  = i_in_item.new_value;
        w_imm_push   = 1'b0;
        w_tree_start = 1'b0;
        n_count      = r_count;
        w_res.read_value = '0;
        w_res.status     = ST_OK;
        if (w_accept) begin
            case (i_in_item.mode)
                MODE_INSERT: begin
                    w_imm_push = 1'b1;
                    if (w_full) begin
                        w_res.status = ST_FULL;
                    end else begin
                        if (w_pos > w_cnt) begin
                            w_res.status = ST_PAST;
                            w_ctl.pos    = w_cnt;
                        end
                        w_ctl.op = CELL_INSERT;
                        n_count  = r_count + CW'(1);
                    end
                end
                MODE_ERASE: begin
                    w_imm_push = 1'b1;
                    if (w_empty) begin
                        w_res.status = ST_EMPTY;
                    end else begin
                        if (w_pos > w_cnt) begin
                            w_res.status = ST_PAST;
                        end
                        if (w_pos >= w_cnt) begin
                            w_ctl.pos = w_cnt - POS_W'(1);
                        end
                        w_ctl.op = CELL_ERASE;
                        n_count  = r_count - CW'(1);
                    end
                end
                MODE_READ: begin
                    if (w_empty) begin
                        w_imm_push   = 1'b1;
                        w_res.status = ST_EMPTY;
                    end else begin
                        // value comes back through the tree
                        w_tree_start = 1'b1;
                        w_ctl.op     = CELL_READ;
                        if (w_pos >= w_cnt) begin
                            w_res.status = ST_PAST;
                            w_ctl.pos    = w_cnt - POS_W'(1);
                        end
                    end
                end
                default: begin
                    w_imm_push = 1'b1;
                end
            endcase
        end
        w_res.entry_count = 7'(n_count);
    end

    always_comb begin
        w_push_item = w_res;
        if (w_tree_done) begin
            w_push_item            = r_pend;
            w_push_item.read_value = w_tree_val;
        end
    end
    assign w_push = w_imm_push || w_tree_done;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plie_cell u_cell (
            .i_clk    (i_clk),
            .i_index  (POS_W'(g)),
            .i_ctl    (w_ctl),
            .i_left   (w_entry[(g == 0) ? 0 : g - 1]),
            .i_right  (w_entry[(g == CAPACITY - 1) ? g : g + 1]),
            .o_entry  (w_entry[g]),
            .o_rd_val (w_rd[g])
        );
    end

    plie_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_vals (w_rd),
        .o_val  (w_tree_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_busy   <= 1'b0;
            r_wait   <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fcnt   <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_tree_start) begin
                r_busy <= 1'b1;
                r_wait <= LW'(L - 1);
            end else if (w_tree_done) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_wait <= r_wait - LW'(1);
            end
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_fcnt <= r_fcnt + 2'd1;
                2'b01:   r_fcnt <= r_fcnt - 2'd1;
                default: r_fcnt <= r_fcnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tree_start) begin
            r_pend <= w_res;
        end
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_push_item;
        end
    end

endmodule
`default_nettype wire

[rtl/core/plie_cell.sv]
// One list entry cell: holds a value, shifts from either neighbor.
`default_nettype none
module plie_cell
    import plie_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic [POS_W-1:0]    i_index,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic [DATA_W-1:0]   i_left,
    input  wire logic [DATA_W-1:0]   i_right,
    output logic [DATA_W-1:0]        o_entry,
    output logic [DATA_W-1:0]        o_rd_val
);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_index > i_ctl.pos) begin
                    n_entry = i_left;
                end else if (i_index == i_ctl.pos) begin
                    n_entry = i_ctl.value;
                end
            end
            CELL_ERASE: begin
                if (i_index >= i_ctl.pos) begin
                    n_entry = i_right;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry  = r_entry;
    assign o_rd_val = (i_ctl.op == CELL_READ && i_ctl.pos == i_index) ? r_entry : '0;

endmodule
`default_nettype wire

[rtl/core/plie_or_tree.sv]
// Registered OR-reduction tree that collects the one selected cell value.
`default_nettype none
module plie_or_tree
    import plie_pkg::*;
#(
    parameter int N = 64
) (
    input  wire logic              i_clk,
    input  wire logic [DATA_W-1:0] i_vals [N],
    output logic [DATA_W-1:0]      o_val
);

    localparam int L  = tree_levels(N);
    localparam int P  = TREE_RADIX ** L;
    localparam int W0 = P / TREE_RADIX;

    logic [DATA_W-1:0] w_pad  [P];
    logic [DATA_W-1:0] r_node [L][W0];

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_pad[i] = i_vals[i];
        end
        for (int i = N; i < P; i++) begin
            w_pad[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DATA_W-1:0] acc;
        for (int lv = 0; lv < L; lv++) begin
            for (int j = 0; j < W0; j++) begin
                acc = '0;
                for (int k = 0; k < TREE_RADIX; k++) begin
                    if (lv == 0) begin
                        acc = acc | w_pad[j*TREE_RADIX + k];
                    end else if (j*TREE_RADIX + k < W0) begin
                        acc = acc | r_node[lv-1][j*TREE_RADIX + k];
                    end
                end
                r_node[lv][j] <= acc;
            end
        end
    end

    assign o_val = r_node[L-1][0];

endmodule
`default_nettype wire

[verif/tb_positional_list_insert_erase_unit.sv]
// Self-checking testbench for the positional list insert/erase unit.
module tb_positional_list_insert_erase_unit
    import plie_pkg::*;
();

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    localparam int LIST_CAP     = 64;
    localparam int RANDOM_ITEMS = 800;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic signed [31:0] V_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] V_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] V_ONES = 32'shFFFF_FFFF;
    localparam logic signed [31:0] V_ALT0 = 32'sh5555_5555;
    localparam logic signed [31:0] V_ALT1 = 32'shAAAA_AAAA;
    localparam logic signed [31:0] V_ZERO = 32'sh0;

    localparam t_out_item NO_WANT = '{V_ZERO, 7'd0, ST_OK};

    typedef enum int {
        FILL_RUN,
        DRAIN_RUN,
        MIXED_RUN
    } t_run_kind;

    typedef struct {
        t_in_item  op;
        bit        has_want;
        t_out_item want;
    } t_script_row;

    // Directed opening: empty list, extremes of value and position, past-end clamps.
    t_script_row script [25] = '{
        '{'{MODE_READ,   V_ZERO, 8'd0},   1'b1, '{V_ZERO, 7'd0, ST_EMPTY}},
        '{'{MODE_ERASE,  V_ZERO, 8'd0},   1'b1, '{V_ZERO, 7'd0, ST_EMPTY}},
        '{'{MODE_ERASE,  V_ZERO, 8'd255}, 1'b1, '{V_ZERO, 7'd0, ST_EMPTY}},
        '{'{MODE_NOP,    V_ONES, 8'd255}, 1'b1, '{V_ZERO, 7'd0, ST_OK}},
        '{'{MODE_INSERT, V_MAX,  8'd0},   1'b1, '{V_ZERO, 7'd1, ST_OK}},
        '{'{MODE_INSERT, V_MIN,  8'd5},   1'b1, '{V_ZERO, 7'd2, ST_PAST}},
        '{'{MODE_INSERT, V_ONES, 8'd2},   1'b1, '{V_ZERO, 7'd3, ST_OK}},
        '{'{MODE_INSERT, V_ZERO, 8'd1},   1'b1, '{V_ZERO, 7'd4, ST_OK}},
        '{'{MODE_READ,   V_ZERO, 8'd0},   1'b1, '{V_MAX,  7'd4, ST_OK}},
        '{'{MODE_READ,   V_ZERO, 8'd3},   1'b1, '{V_ONES, 7'd4, ST_OK}},
        '{'{MODE_READ,   V_ZERO, 8'd4},   1'b1, '{V_ONES, 7'd4, ST_PAST}},
        '{'{MODE_READ,   V_ZERO, 8'd255}, 1'b1, '{V_ONES, 7'd4, ST_PAST}},
        '{'{MODE_READ,   V_ZERO, 8'd2},   1'b1, '{V_MIN,  7'd4, ST_OK}},
        '{'{MODE_INSERT, V_ALT0, 8'd255}, 1'b1, '{V_ZERO, 7'd5, ST_PAST}},
        '{'{MODE_INSERT, V_ALT1, 8'd3},   1'b0, NO_WANT},
        '{'{MODE_READ,   V_ZERO, 8'd3},   1'b0, NO_WANT},
        '{'{MODE_ERASE,  V_ZERO, 8'd6},   1'b0, NO_WANT},
        '{'{MODE_ERASE,  V_ZERO, 8'd200}, 1'b1, '{V_ZERO, 7'd4, ST_PAST}},
        '{'{MODE_ERASE,  V_ZERO, 8'd0},   1'b0, NO_WANT},
        '{'{MODE_READ,   V_ZERO, 8'd0},   1'b0, NO_WANT},
        '{'{MODE_ERASE,  V_ZERO, 8'd1},   1'b0, NO_WANT},
        '{'{MODE_READ,   V_ONES, 8'd128}, 1'b0, NO_WANT},
        '{'{MODE_ERASE,  V_ZERO, 8'd1},   1'b0, NO_WANT},
        '{'{MODE_ERASE,  V_ZERO, 8'd255}, 1'b0, NO_WANT},
        '{'{MODE_READ,   V_ZERO, 8'd0},   1'b1, '{V_ZERO, 7'd0, ST_EMPTY}}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    logic signed [31:0] shadow_list [$];
    t_out_item          replies_due [$];
    int                 errors       = 0;
    int                 replies_seen = 0;
    int                 idle_cycles  = 0;
    bit                 valid_up     = 1'b0;
    int                 burst_left   = 1;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    positional_list_insert_erase_unit #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    // Applies one operation to the shadow list and returns the reply it produces.
    function automatic t_out_item apply_list_op(input t_in_item op);
        t_out_item r;
        int        pos;
        int        size;
        r    = NO_WANT;
        pos  = op.position;
        size = shadow_list.size();
        case (op.mode)
            MODE_INSERT: begin
                if (size >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    if (pos > size) begin
                        r.status = ST_PAST;
                        pos = size;
                    end
                    shadow_list.insert(pos, op.new_value);
                end
            end
            MODE_ERASE: begin
                if (size == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (pos > size) r.status = ST_PAST;
                    if (pos >= size) pos = size - 1;
                    shadow_list.delete(pos);
                end
            end
            MODE_READ: begin
                if (size == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // a read at exactly the count is already past the end
                    if (pos >= size) begin
                        r.status = ST_PAST;
                        pos = size - 1;
                    end
                    r.read_value = shadow_list[pos];
                end
            end
            default: ;
        endcase
        r.entry_count = 7'(shadow_list.size());
        return r;
    endfunction

    // Offers one item, waits for its transfer, then logs the reply it must produce.
    task automatic offer_item(input t_in_item op, input bit has_want, input t_out_item want);
        t_out_item predicted;
        i_in_item <= op;
        if (!valid_up) begin
            i_in_valid <= 1'b1;
            valid_up = 1'b1;
        end
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = apply_list_op(op);
        replies_due.insert(replies_due.size(), has_want ? want : predicted);
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            i_in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        t_in_item  item;
        t_run_kind run_kind;
        int        size;
        int        roll;
        int        pos;
        int        left;
        int        ins_lim;
        int        ers_lim;
        int        n_sent;
        bit        drained_once;
        n_sent = 0;
        drained_once = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) offer_item(script[k].op, script[k].has_want, script[k].want);

        while (n_sent < RANDOM_ITEMS) begin
            if (!drained_once && n_sent >= RANDOM_ITEMS / 2) begin
                // pause the input until every reply is back
                if (valid_up) begin
                    i_in_valid <= 1'b0;
                    valid_up = 1'b0;
                    @(posedge i_clk);
                end
                while (replies_due.size() != 0) @(posedge i_clk);
                drained_once = 1'b1;
            end
            run_kind = t_run_kind'($urandom_range(0, 2));
            case (run_kind)
                FILL_RUN: begin
                    ins_lim = 80;
                    ers_lim = 86;
                    left = $urandom_range(1, 6);
                end
                DRAIN_RUN: begin
                    ins_lim = 6;
                    ers_lim = 86;
                    left = $urandom_range(1, 6);
                end
                default: begin
                    ins_lim = 32;
                    ers_lim = 62;
                    left = $urandom_range(20, 40);
                end
            endcase
            // fill and drain runs go on past the full/empty edge for a few items
            while (left > 0) begin
                size = shadow_list.size();
                roll = $urandom_range(0, 99);
                if (roll < ins_lim) item.mode = MODE_INSERT;
                else if (roll < ers_lim) item.mode = MODE_ERASE;
                else if (roll < 96) item.mode = MODE_READ;
                else item.mode = MODE_NOP;

                case ($urandom_range(0, 15))
                    0: item.new_value = V_MAX;
                    1: item.new_value = V_MIN;
                    default: item.new_value = $urandom;
                endcase

                roll = $urandom_range(0, 99);
                if (roll < 60) pos = $urandom_range(0, size);
                else if (roll < 72) pos = size;
                else if (roll < 80) pos = (size == 0) ? 0 : size - 1;
                else if (roll < 92) pos = $urandom_range(size, 255);
                else if (roll < 96) pos = 255;
                else pos = 0;
                item.position = pos[7:0];

                offer_item(item, 1'b0, NO_WANT);
                n_sent++;
                if (run_kind == MIXED_RUN
                        || (run_kind == FILL_RUN && shadow_list.size() == LIST_CAP)
                        || (run_kind == DRAIN_RUN && shadow_list.size() == 0))
                    left--;
            end
        end

        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Output stall pattern: runs of random stall density, plus one long hold-off.
    initial begin : reply_stall_pattern
        int stall_pct;
        int span;
        bit long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            span = $urandom_range(8, 60);
            repeat (span) begin
                @(posedge i_clk);
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
            if (!long_hold_done && replies_seen >= HOLD_AFTER) begin
                // result queue fills up and the input side has to stall
                repeat (LONG_HOLD) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
                long_hold_done = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            replies_seen++;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply: expected none, actual %p", $time, o_out_item);
                errors++;
            end else begin
                want = replies_due.pop_front();
                if (o_out_item.read_value !== want.read_value) begin
                    $display("%0t: read_value mismatch: expected %0d, actual %0d",
                             $time, want.read_value, o_out_item.read_value);
                    errors++;
                end
                if (o_out_item.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $time, want.entry_count, o_out_item.entry_count);
                    errors++;
                end
                if (o_out_item.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_out_item.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
